[src/pls_pkg.sv]
`timescale 1ns / 1ps

package pls_pkg;

  // Fractional bits of the log10 table entries.
  localparam int unsigned LOG_FRAC_BITS = 24;

  // log10(256) is below 4, so two integer bits are enough.
  localparam int unsigned LOG_W = LOG_FRAC_BITS + 2;
  // The divisor is a table entry in log mode and an 8-bit span in stretch mode.
  localparam int unsigned DEN_W = LOG_W;
  // The numerator is 255 times a value no wider than the divisor.
  localparam int unsigned NUM_W = DEN_W + 8;

  localparam int unsigned QUOT_W = 8;
  localparam int unsigned DIV_STAGES = QUOT_W;

  localparam int unsigned LOG2_FRAC = 48;
  localparam logic [63:0] LOG10_OF_2_Q64 = 64'd5553023288523357132;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 2'd2;

  localparam logic MODE_LOG = 1'b0;
  localparam logic MODE_STRETCH = 1'b1;

  localparam logic [7:0] PIX_BLACK = 8'd0;
  localparam logic [7:0] PIX_WHITE = 8'd255;

  typedef logic [255:0][LOG_W-1:0] log_tbl_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] min_level;
    logic [7:0] max_level;
  } cfg_t;

  // One pipeline slot. A bypass item already carries its final pixel in quot.
  typedef struct packed {
    logic              valid;
    logic              bypass;
    logic              clip;
    logic              err;
    logic [QUOT_W-1:0] quot;
    logic [DEN_W-1:0]  rem;
    logic [7:0]        low;
    logic [DEN_W-1:0]  den;
  } pipe_t;

  // One table entry: log2 by repeated squaring of the mantissa, scaled to
  // log10, then rounded to LOG_FRAC_BITS fractional bits.
  function automatic logic [LOG_W-1:0] log10_entry(input int unsigned v);
    logic [63:0]  x;
    logic [63:0]  y;
    logic [63:0]  frac;
    logic [63:0]  l2;
    logic [63:0]  hi;
    logic [127:0] sq;
    logic [127:0] pr;
    logic [63:0]  rounded;
    int unsigned  n;
    x = 64'(v + 1);
    n = 0;
    while ((n < 8) && ((x >> (n + 1)) != 64'd0)) begin
      n++;
    end
    y = x << (62 - n);
    frac = 64'd0;
    for (int i = 0; i < LOG2_FRAC; i++) begin
      sq = {64'd0, y} * {64'd0, y};
      y = sq[125:62];
      frac = frac << 1;
      if (y[63]) begin
        y = y >> 1;
        frac = frac | 64'd1;
      end
    end
    l2 = (64'(n) << LOG2_FRAC) | frac;
    pr = {64'd0, l2} * {64'd0, LOG10_OF_2_Q64};
    hi = pr[127:64];
    rounded = ((hi >> (47 - LOG_FRAC_BITS)) + 64'd1) >> 1;
    return rounded[LOG_W-1:0];
  endfunction

  function automatic log_tbl_t build_log_tbl();
    log_tbl_t t;
    for (int v = 0; v < 256; v++) begin
      t[v] = log10_entry(v);
    end
    return t;
  endfunction

  localparam log_tbl_t LOG_TBL = build_log_tbl();

endpackage

[src/pls_front.sv]
`timescale 1ns / 1ps

module pls_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_in,
  input  logic [7:0]          pixel,
  input  pls_pkg::cfg_t       cfg,
  output pls_pkg::pipe_t      stage_r
);

  pls_pkg::pipe_t                  stage_nxt;
  logic [pls_pkg::LOG_W-1:0]       t_pix;
  logic [pls_pkg::LOG_W-1:0]       t_max;
  logic [pls_pkg::NUM_W-1:0]       num_log;
  logic [7:0]                      span;
  logic [7:0]                      offset;
  logic [15:0]                     num_str;
  logic [pls_pkg::NUM_W-1:0]       num;

  assign t_pix = pls_pkg::LOG_TBL[pixel];
  assign t_max = pls_pkg::LOG_TBL[cfg.max_level];

  // 255 * x is formed as (x << 8) - x.
  assign num_log = {t_pix, 8'd0} - pls_pkg::NUM_W'(t_pix);
  assign offset  = pixel - cfg.min_level;
  assign span    = cfg.max_level - cfg.min_level;
  assign num_str = {offset, 8'd0} - 16'(offset);

  always_comb begin
    stage_nxt        = '0;
    stage_nxt.valid  = valid_in;
    num              = num_log;
    stage_nxt.den    = t_max;
    if (cfg.mode == pls_pkg::MODE_LOG) begin
      if (t_max == '0) begin
        stage_nxt.bypass = 1'b1;
        stage_nxt.err    = 1'b1;
        stage_nxt.quot   = pls_pkg::PIX_BLACK;
      end else if (pixel > cfg.max_level) begin
        stage_nxt.bypass = 1'b1;
        stage_nxt.clip   = 1'b1;
        stage_nxt.quot   = pls_pkg::PIX_WHITE;
      end
    end else begin
      num           = pls_pkg::NUM_W'(num_str);
      stage_nxt.den = pls_pkg::DEN_W'(span);
      if (cfg.max_level <= cfg.min_level) begin
        stage_nxt.bypass = 1'b1;
        stage_nxt.err    = 1'b1;
        stage_nxt.quot   = pls_pkg::PIX_BLACK;
      end else if (pixel < cfg.min_level) begin
        stage_nxt.bypass = 1'b1;
        stage_nxt.clip   = 1'b1;
        stage_nxt.quot   = pls_pkg::PIX_BLACK;
      end else if (pixel > cfg.max_level) begin
        stage_nxt.bypass = 1'b1;
        stage_nxt.clip   = 1'b1;
        stage_nxt.quot   = pls_pkg::PIX_WHITE;
      end
    end
    // The quotient fits in eight bits, so the upper part of the numerator is
    // already below the divisor and serves as the first partial remainder.
    stage_nxt.rem = num[pls_pkg::NUM_W-1:8];
    stage_nxt.low = num[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

endmodule

[src/pls_div_stage.sv]
`timescale 1ns / 1ps

module pls_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  pls_pkg::pipe_t stage_in,
  output pls_pkg::pipe_t stage_r
);

  pls_pkg::pipe_t              stage_nxt;
  logic [pls_pkg::DEN_W:0]     trial;
  logic [pls_pkg::DEN_W:0]     diff;
  logic                        ge;

  // One restoring step: bring down the next numerator bit and try to subtract.
  assign trial = {stage_in.rem, stage_in.low[7]};
  assign diff  = trial - {1'b0, stage_in.den};
  assign ge    = (trial >= {1'b0, stage_in.den});

  always_comb begin
    stage_nxt = stage_in;
    if (!stage_in.bypass) begin
      stage_nxt.rem  = ge ? diff[pls_pkg::DEN_W-1:0] : trial[pls_pkg::DEN_W-1:0];
      stage_nxt.low  = {stage_in.low[6:0], 1'b0};
      stage_nxt.quot = {stage_in.quot[pls_pkg::QUOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

endmodule

[src/pixel_log_and_stretch.sv]
`timescale 1ns / 1ps

// Channel        Ports                                                         Direction
// -------------  ------------------------------------------------------------  ---------
// input pixel    start, busy, in_pixel_in[7:0]                                 in
// result pixel   out_strobe, out_pixel_out[7:0], out_clipped, out_range_error  out
// configuration  cfg_we, cfg_index[1:0], cfg_data[7:0]                         in
//
// One pixel can be transferred in every cycle; busy is always low. Each pixel
// passes through one front stage (table lookups, range checks and the
// multiply by 255) and eight divider stages, one quotient bit each.
// Reset is synchronous and active low; it clears the stage valid bits and
// loads the register reset values. The receiver cannot stall, so the pipeline
// advances every cycle and a result is shown for exactly one cycle.

module pixel_log_and_stretch (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    in_pixel_in,
  output logic                          out_strobe,
  output logic [7:0]                    out_pixel_out,
  output logic                          out_clipped,
  output logic                          out_range_error,
  input  logic                          cfg_we,
  input  logic [pls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  pls_pkg::cfg_t  cfg_r;
  pls_pkg::cfg_t  cfg_nxt;
  pls_pkg::pipe_t stages [pls_pkg::DIV_STAGES+1];
  logic           accept;

  // The pipeline never backs up, so a new pixel is always welcome.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers. An index past the last register is ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pls_pkg::CFG_MODE:      cfg_nxt.mode      = cfg_data[0];
        pls_pkg::CFG_MIN_LEVEL: cfg_nxt.min_level = cfg_data;
        pls_pkg::CFG_MAX_LEVEL: cfg_nxt.max_level = cfg_data;
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= pls_pkg::MODE_LOG;
      cfg_r.min_level <= pls_pkg::PIX_BLACK;
      cfg_r.max_level <= pls_pkg::PIX_WHITE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front stage: picks the mode, resolves the special cases and sets up the
  // numerator and divisor. Items that need no division are marked bypass and
  // already carry their final pixel.
  pls_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_in (accept),
    .pixel    (in_pixel_in),
    .cfg      (cfg_r),
    .stage_r  (stages[0])
  );

  // Divider: a chain of restoring steps, most significant quotient bit first.
  for (genvar k = 0; k < pls_pkg::DIV_STAGES; k++) begin : g_div
    pls_div_stage u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .stage_in (stages[k]),
      .stage_r  (stages[k+1])
    );
  end

  assign out_strobe      = stages[pls_pkg::DIV_STAGES].valid;
  assign out_pixel_out   = stages[pls_pkg::DIV_STAGES].quot;
  assign out_clipped     = stages[pls_pkg::DIV_STAGES].clip;
  assign out_range_error = stages[pls_pkg::DIV_STAGES].err;

  // A clamped pixel never also reports a bad divisor.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_clipped && out_range_error))
    else $error("clipped and range_error both set");

  // A bad divisor always yields black.
  a_error_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_range_error) |-> (out_pixel_out == pls_pkg::PIX_BLACK))
    else $error("range_error with nonzero pixel");

  // A clamped pixel is black or white.
  a_clip_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_clipped) |->
      (out_pixel_out == pls_pkg::PIX_BLACK || out_pixel_out == pls_pkg::PIX_WHITE))
    else $error("clipped pixel not at an extreme");

  // Every accepted pixel occupies the front stage on the next cycle.
  a_front_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (stages[0].valid == $past(accept)))
    else $error("front stage valid does not follow the input transfer");

endmodule

[tb/tb_pixel_log_and_stretch.sv]
`timescale 1ns / 1ps

// Self-checking bench for the grayscale log / contrast stretch pipeline.
// Pixels go in through the start/busy command port, and results come back one
// cycle each on the strobe port. Every accepted pixel gets its expected result
// from a local model of the point operation. That model builds its own log10
// table and is checked against each result in arrival order.
module tb_pixel_log_and_stretch;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned IDLE_PERCENT = 27;
  // The pipeline is nine stages deep, so this is plenty of quiet time at the end.
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned RANDOM_PHASES = 16;
  // This phase runs back to back with no sender gaps at all.
  localparam int unsigned BURST_PHASE = 5;
  localparam int unsigned BURST_ITEMS = 250;
  // Register index 3 is outside the register list and must be ignored.
  localparam logic [pls_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  // log10(2) as an unsigned fraction with 64 bits.
  localparam logic [63:0] LOG10_2_Q64 = 64'd5553023288523357132;

  typedef struct packed {
    logic [7:0] pixel;
    logic       clipped;
    logic       range_error;
  } pixel_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [7:0]                    in_pixel_in = 8'd0;
  logic                          out_strobe;
  logic [7:0]                    out_pixel_out;
  logic                          out_clipped;
  logic                          out_range_error;
  logic                          cfg_we = 1'b0;
  logic [pls_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]                    cfg_data = 8'd0;

  // These are the expected results in transfer order, and the register values
  // that the block should currently hold.
  pixel_result_t pending_results[$];
  pls_pkg::cfg_t shadow_cfg;
  logic [63:0]   log10_q[256];

  int unsigned error_count = 0;
  int unsigned result_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_enabled = 1'b1;

  pixel_log_and_stretch DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_pixel_in    (in_pixel_in),
    .out_strobe     (out_strobe),
    .out_pixel_out  (out_pixel_out),
    .out_clipped    (out_clipped),
    .out_range_error(out_range_error),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  // This function gives log10(1+v) in fixed point. First it takes log2 with 48
  // fractional bits: the mantissa is squared repeatedly, and one fraction bit
  // drops out each time the square reaches 2. Then the value is scaled by
  // log10(2) and rounded to the table's fractional width.
  function automatic logic [63:0] log10_fixed(input int unsigned v);
    logic [127:0] wide;
    logic [63:0]  mant;
    logic [63:0]  bits;
    logic [63:0]  l2;
    int unsigned  expo;
    expo = 0;
    while (expo < 8 && ((v + 1) >> (expo + 1)) != 0) begin
      expo++;
    end
    mant = 64'(v + 1) << (62 - expo);
    bits = 64'd0;
    repeat (48) begin
      wide = {64'd0, mant} * {64'd0, mant};
      mant = wide[125:62];
      bits = {bits[62:0], mant[63]};
      if (mant[63]) begin
        mant = mant >> 1;
      end
    end
    l2 = (64'(expo) << 48) | bits;
    wide = {64'd0, l2} * {64'd0, LOG10_2_Q64};
    return ((wide[127:64] >> (47 - pls_pkg::LOG_FRAC_BITS)) + 64'd1) >> 1;
  endfunction

  // This is the point operation for one pixel under the given register values.
  function automatic pixel_result_t transform_pixel(input logic [7:0] pix,
                                                    input pls_pkg::cfg_t cfg);
    pixel_result_t r;
    logic [63:0]   den;
    logic [63:0]   quo;
    r = '0;
    if (cfg.mode == pls_pkg::MODE_LOG) begin
      den = log10_q[cfg.max_level];
      if (den == 64'd0) begin
        r.range_error = 1'b1;
      end else if (pix > cfg.max_level) begin
        r.pixel = pls_pkg::PIX_WHITE;
        r.clipped = 1'b1;
      end else begin
        quo = (64'd255 * log10_q[pix]) / den;
        r.pixel = (quo > 64'd255) ? pls_pkg::PIX_WHITE : quo[7:0];
      end
    end else begin
      if (cfg.max_level <= cfg.min_level) begin
        r.range_error = 1'b1;
      end else if (pix < cfg.min_level) begin
        r.pixel = pls_pkg::PIX_BLACK;
        r.clipped = 1'b1;
      end else if (pix > cfg.max_level) begin
        r.pixel = pls_pkg::PIX_WHITE;
        r.clipped = 1'b1;
      end else begin
        quo = (64'(pix - cfg.min_level) * 64'd255) / 64'(cfg.max_level - cfg.min_level);
        r.pixel = quo[7:0];
      end
    end
    return r;
  endfunction

  // Levels lean toward the ends of the 8-bit range, where the arithmetic is
  // most likely to break.
  function automatic logic [7:0] rand_level();
    case ($urandom_range(5, 0))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(3, 1));
      3: return 8'($urandom_range(254, 252));
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  // About a third of the pixels fall inside the active range. The others sit on
  // its edges, just outside it, anywhere outside it, or anywhere at all.
  function automatic logic [7:0] pick_pixel();
    int unsigned lo;
    int unsigned hi;
    lo = (shadow_cfg.mode == pls_pkg::MODE_LOG) ? 0 : shadow_cfg.min_level;
    hi = shadow_cfg.max_level;
    case ($urandom_range(9, 0))
      5, 6, 7: begin
        if (lo <= hi) begin
          return 8'($urandom_range(hi, lo));
        end
        return 8'($urandom);
      end
      8: begin
        case ($urandom_range(3, 0))
          0: return 8'(lo);
          1: return 8'(hi);
          2: return 8'(lo - 1);
          default: return 8'(hi + 1);
        endcase
      end
      9: begin
        if (hi < 255 && ($urandom_range(1, 0) == 1 || lo == 0)) begin
          return 8'($urandom_range(255, hi + 1));
        end else if (lo > 0) begin
          return 8'($urandom_range(lo - 1, 0));
        end
        return 8'($urandom);
      end
      default: return 8'($urandom);
    endcase
  endfunction

  // This task sends one pixel. When idling is enabled it may first leave the
  // port idle and drive junk data while start is low. It returns at the edge
  // of the transfer with start still high, so a following pixel can go out in
  // the very next cycle.
  task automatic send_pixel(input logic [7:0] pix);
    while (idle_enabled && $urandom_range(99, 0) < IDLE_PERCENT) begin
      start <= 1'b0;
      in_pixel_in <= 8'($urandom);
      @(posedge clk);
    end
    start <= 1'b1;
    in_pixel_in <= pix;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    pending_results.push_back(transform_pixel(pix, shadow_cfg));
  endtask

  // This task stops sending and waits until every outstanding pixel has come
  // back. It lets the clock advance before it checks, so start is never
  // lowered and raised within the same step.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // This task writes one register and leaves cfg_we high. apply_config lowers it
  // once the whole burst of writes is done.
  task automatic write_reg(input logic [pls_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      pls_pkg::CFG_MODE:      shadow_cfg.mode = data[0];
      pls_pkg::CFG_MIN_LEVEL: shadow_cfg.min_level = data;
      pls_pkg::CFG_MAX_LEVEL: shadow_cfg.max_level = data;
      default: ;
    endcase
  endtask

  // This task writes all three registers while the pipeline is empty. The mode
  // write carries random upper bits, since only bit 0 should count. If asked,
  // it also writes the unused index, which must change nothing.
  task automatic apply_config(input logic m, input logic [7:0] lo, input logic [7:0] hi,
                              input bit touch_spare);
    write_reg(pls_pkg::CFG_MODE, {7'($urandom), m});
    if (touch_spare) begin
      write_reg(CFG_SPARE, 8'($urandom));
    end
    write_reg(pls_pkg::CFG_MIN_LEVEL, lo);
    write_reg(pls_pkg::CFG_MAX_LEVEL, hi);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Right after reset the block is in log mode with max_level 255. These
  // pixels cover both ends of the input range and the middle.
  task automatic test_reset_values();
    logic [7:0] pix_list[6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    foreach (pix_list[i]) begin
      send_pixel(pix_list[i]);
    end
    drain_pipeline();
  endtask

  // Log mode cases: a zero max_level gives a zero divisor. Pixels above
  // max_level clamp to white. min_level must not matter in this mode.
  task automatic test_log_corners();
    apply_config(pls_pkg::MODE_LOG, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd0);
    send_pixel(8'd255);
    drain_pipeline();
    apply_config(pls_pkg::MODE_LOG, 8'd255, 8'd1, 1'b0);
    send_pixel(8'd0);
    send_pixel(8'd1);
    send_pixel(8'd2);
    drain_pipeline();
    apply_config(pls_pkg::MODE_LOG, 8'd37, 8'd100, 1'b1);
    send_pixel(8'd99);
    send_pixel(8'd100);
    send_pixel(8'd101);
    drain_pipeline();
  endtask

  // Stretch mode cases: the full range, clamping below and above the range,
  // an empty range, an inverted range, and the narrowest valid range.
  task automatic test_stretch_corners();
    apply_config(pls_pkg::MODE_STRETCH, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd0);
    send_pixel(8'd255);
    drain_pipeline();
    apply_config(pls_pkg::MODE_STRETCH, 8'd50, 8'd200, 1'b0);
    send_pixel(8'd49);
    send_pixel(8'd50);
    send_pixel(8'd125);
    send_pixel(8'd200);
    send_pixel(8'd201);
    drain_pipeline();
    apply_config(pls_pkg::MODE_STRETCH, 8'd77, 8'd77, 1'b1);
    send_pixel(8'd77);
    drain_pipeline();
    apply_config(pls_pkg::MODE_STRETCH, 8'd200, 8'd100, 1'b0);
    send_pixel(8'd150);
    drain_pipeline();
    apply_config(pls_pkg::MODE_STRETCH, 8'd254, 8'd255, 1'b0);
    send_pixel(8'd253);
    send_pixel(8'd254);
    send_pixel(8'd255);
    drain_pipeline();
  endtask

  // Each random phase draws a new register setting and then streams pixels.
  // Stretch settings are mostly well formed, so that the divide path gets most
  // of the traffic. Every phase ends with the sender holding off until the
  // pipeline is empty, and one phase runs with no gaps at all.
  task automatic test_random_phases();
    int unsigned n_items;
    logic        m;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  swap;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      n_items = (ph == BURST_PHASE) ? BURST_ITEMS : $urandom_range(120, 60);
      idle_enabled = (ph != BURST_PHASE);
      m = 1'($urandom_range(1, 0));
      lo = rand_level();
      hi = rand_level();
      if (m == pls_pkg::MODE_STRETCH && $urandom_range(99, 0) < 80) begin
        if (lo > hi) begin
          swap = lo;
          lo = hi;
          hi = swap;
        end
        if (lo == hi) begin
          if (hi < 8'd255) begin
            hi = hi + 8'd1;
          end else begin
            lo = lo - 8'd1;
          end
        end
      end
      apply_config(m, lo, hi, $urandom_range(3, 0) == 0);
      repeat (n_items) begin
        send_pixel(pick_pixel());
      end
      drain_pipeline();
    end
    idle_enabled = 1'b1;
  endtask

  // A result is taken at the edge that ends its strobe cycle. It is matched
  // against the oldest expectation. The values seen here are the ones from
  // before the edge, so nothing depends on the order of events in the step.
  always @(posedge clk) begin : check_result
    pixel_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("result %0d arrived with nothing expected: pixel=%0d clipped=%b err=%b",
                   result_count, out_pixel_out, out_clipped, out_range_error);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_pixel_out !== want.pixel || out_clipped !== want.clipped ||
            out_range_error !== want.range_error) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("result %0d: want pixel=%0d clip=%b err=%b, got pixel=%0d clip=%b err=%b",
                     result_count, want.pixel, want.clipped, want.range_error,
                     out_pixel_out, out_clipped, out_range_error);
          end
        end
      end
      result_count++;
    end
  end

  // This watchdog ends a run that hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    for (int v = 0; v < 256; v++) begin
      log10_q[v] = log10_fixed(v);
    end
    shadow_cfg.mode = pls_pkg::MODE_LOG;
    shadow_cfg.min_level = 8'd0;
    shadow_cfg.max_level = 8'd255;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_log_corners();
    test_stretch_corners();
    test_random_phases();

    drain_pipeline();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[pixel_log_and_stretch.f]
src/pls_pkg.sv
src/pls_front.sv
src/pls_div_stage.sv
src/pixel_log_and_stretch.sv
tb/tb_pixel_log_and_stretch.sv
